@@ rtl/capture_point_pd_stabilizer_unit_macros.svh @@
// Assertion macros for the capture point stabilizer RTL.
`ifndef CAPTURE_POINT_PD_STABILIZER_UNIT_MACROS_SVH
`define CAPTURE_POINT_PD_STABILIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define CPS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CPS_ASSERT_IMP(label, ante, cons, msg)
`define CPS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/cps_pkg.sv @@
// Types, constants and helpers for the capture point stabilizer.
package cps_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GAIN_FRAC = 24;
   localparam logic [31:0] RECIP_G = 32'd437815219;   // round(2^32 / 9.81)

   localparam int SHR_RECIP = 32 - FRAC_BITS;
   localparam int SHR_FRAC  = FRAC_BITS;
   localparam int SHR_GAIN  = GAIN_FRAC;

   // height * RECIP_G < 2^60, shifted right by 32 - FRAC_BITS
   localparam int Q_W    = 28 + FRAC_BITS;
   localparam int SQ_W   = Q_W + (Q_W % 2);
   localparam int ROOT_W = SQ_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W);

   localparam int OPA_W  = 34;
   localparam int MAG_W  = 33;
   localparam int PROD_W = MAG_W + 32;
   localparam int RES_W  = PROD_W + 1;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REG_MODE,
      REG_KP_X,
      REG_KP_Y,
      REG_KD_X,
      REG_KD_Y,
      REG_REF_X,
      REG_REF_Y,
      REG_INV_DT
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_Q,
      OP_VX,
      OP_VY,
      OP_DX,
      OP_DY,
      OP_PX,
      OP_DKX,
      OP_PY,
      OP_DKY
   } op_type;

   typedef enum logic [1:0] {
      SH_RECIP,
      SH_FRAC,
      SH_GAIN
   } sh_type;

   typedef struct packed {
      logic   cap_in;
      logic   mul_go;
      logic   wb_en;
      logic   sqrt_step;
      logic   out_load;
      op_type op;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] v);
      logic [RES_W-32:0] top;
      top = v[RES_W-1:31];
      if ((&top) || (~|top)) begin
         return v[31:0];
      end else if (v[RES_W-1]) begin
         return S32_MIN;
      end else begin
         return S32_MAX;
      end
   endfunction

endpackage

@@ rtl/cps_ctrl.sv @@
// Sequencer for the capture point stabilizer: handshakes and step order.
module cps_ctrl import cps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

`include "capture_point_pd_stabilizer_unit_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_Q_ISSUE,
      S_Q_WAIT,
      S_SQRT,
      S_MUL_ISSUE,
      S_MUL_WAIT,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_xfer, out_free;

   function automatic op_type next_op(input op_type op);
      unique case (op)
         OP_VX:   return OP_VY;
         OP_VY:   return OP_DX;
         OP_DX:   return OP_DY;
         OP_DY:   return OP_PX;
         OP_PX:   return OP_DKX;
         OP_DKX:  return OP_PY;
         OP_PY:   return OP_DKY;
         default: return OP_VX;
      endcase
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      cmd      = '{cap_in: 1'b0, mul_go: 1'b0, wb_en: 1'b0, sqrt_step: 1'b0,
                   out_load: 1'b0, op: op_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd.cap_in = 1'b1;
               op_in      = OP_Q;
               state_in   = S_Q_ISSUE;
            end
         end
         S_Q_ISSUE: begin
            cmd.mul_go = 1'b1;
            state_in   = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            cmd.wb_en = 1'b1;
            cnt_in    = CNT_W'(ROOT_W - 1);
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               op_in    = OP_VX;
               state_in = S_MUL_ISSUE;
            end
         end
         S_MUL_ISSUE: begin
            cmd.mul_go = 1'b1;
            state_in   = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            cmd.wb_en = 1'b1;
            if (op_ff == OP_DKY) begin
               state_in = S_DONE;
            end else begin
               op_in    = next_op(op_ff);
               state_in = S_MUL_ISSUE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_Q;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CPS_ASSERT_NXT(a_accept_starts_q, req_xfer, cmd.mul_go && (cmd.op == OP_Q), "no height step after transfer")
   `CPS_ASSERT_IMP(a_load_when_free, cmd.out_load, out_free, "result overwritten before transfer")
   `CPS_ASSERT_NXT(a_load_shows_rsp, cmd.out_load, rsp_valid && !req_stall, "result not shown after load")

endmodule

@@ rtl/cps_datapath.sv @@
// Datapath: config registers, shared multiplier, square root unit, result registers.
module cps_datapath import cps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic signed [31:0] req_com_x,
   input  logic signed [31:0] req_com_y,
   input  logic signed [31:0] req_com_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   output logic signed [31:0] rsp_theta_x,
   output logic signed [31:0] rsp_theta_y,
   output logic signed [31:0] rsp_cp_x,
   output logic signed [31:0] rsp_cp_y
);

   logic                      mode_ff;
   logic [31:0]               kp_x_ff, kp_y_ff, kd_x_ff, kd_y_ff, inv_dt_ff;
   logic signed [31:0]        ref_x_ff, ref_y_ff;
   logic signed [31:0]        prev_full_x_ff, prev_full_y_ff;
   logic signed [31:0]        prev_inst_x_ff, prev_inst_y_ff;

   logic signed [31:0]        com_x_ff, com_y_ff, com_z_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0]        cx_ff, cy_ff, cpdx_ff, cpdy_ff, tx_ff, ty_ff;
   logic signed [RES_W-1:0]   acc_ff;

   logic [SQ_W-1:0]           sq_rad_ff;
   logic [ROOT_W+1:0]         sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]         sq_root_ff, sq_root_in;
   logic [ROOT_W+3:0]         sq_trial, sq_sub;

   logic [PROD_W-1:0]         prod_ff, shifted;
   logic                      neg_ff;
   sh_type                    sh_ff, sh_sel;
   logic signed [OPA_W-1:0]   a_sel;
   logic [31:0]               g_sel;
   logic [MAG_W-1:0]          mag;
   logic signed [RES_W-1:0]   res, com_add;
   logic [30:0]               h;
   logic signed [31:0]        prev_x, prev_y;

   assign h      = com_z_ff[31] ? '0 : com_z_ff[30:0];
   assign prev_x = mode_ff ? prev_inst_x_ff : prev_full_x_ff;
   assign prev_y = mode_ff ? prev_inst_y_ff : prev_full_y_ff;

   // operand select for the shared multiplier
   always_comb begin
      a_sel  = '0;
      g_sel  = '0;
      sh_sel = SH_FRAC;
      case (cmd.op)
         OP_Q: begin
            a_sel  = OPA_W'(h);
            g_sel  = RECIP_G;
            sh_sel = SH_RECIP;
         end
         OP_VX: begin
            a_sel = OPA_W'(vel_x_ff);
            g_sel = 32'(sq_root_ff);
         end
         OP_VY: begin
            a_sel = OPA_W'(vel_y_ff);
            g_sel = 32'(sq_root_ff);
         end
         OP_DX: begin
            a_sel = OPA_W'(cx_ff) - OPA_W'(prev_x);
            g_sel = inv_dt_ff;
         end
         OP_DY: begin
            a_sel = OPA_W'(cy_ff) - OPA_W'(prev_y);
            g_sel = inv_dt_ff;
         end
         OP_PX: begin
            a_sel  = OPA_W'(cx_ff) - OPA_W'(ref_x_ff);
            g_sel  = kp_x_ff;
            sh_sel = SH_GAIN;
         end
         OP_DKX: begin
            a_sel  = OPA_W'(cpdx_ff);
            g_sel  = kd_x_ff;
            sh_sel = SH_GAIN;
         end
         OP_PY: begin
            a_sel  = OPA_W'(cy_ff) - OPA_W'(ref_y_ff);
            g_sel  = kp_y_ff;
            sh_sel = SH_GAIN;
         end
         OP_DKY: begin
            a_sel  = OPA_W'(cpdy_ff);
            g_sel  = kd_y_ff;
            sh_sel = SH_GAIN;
         end
         default: a_sel = '0;
      endcase
   end

   assign mag = a_sel[OPA_W-1] ? MAG_W'(-a_sel) : MAG_W'(a_sel);

   always_comb begin
      case (sh_ff)
         SH_RECIP: shifted = prod_ff >> SHR_RECIP;
         SH_GAIN:  shifted = prod_ff >> SHR_GAIN;
         default:  shifted = prod_ff >> SHR_FRAC;
      endcase
   end

   // truncation toward zero: shift the magnitude, then restore the sign
   assign res     = neg_ff ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
   assign com_add = RES_W'(mode_ff ? 32'sd0 : (cmd.op == OP_VX ? com_x_ff : com_y_ff));

   // one restoring square root step: two radicand bits per cycle
   always_comb begin
      sq_trial = {sq_rem_ff, sq_rad_ff[SQ_W-1 -: 2]};
      sq_sub   = {2'b00, sq_root_ff, 2'b01};
      if (sq_trial >= sq_sub) begin
         sq_rem_in  = (ROOT_W + 2)'(sq_trial - sq_sub);
         sq_root_in = {sq_root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         sq_rem_in  = sq_trial[ROOT_W+1:0];
         sq_root_in = {sq_root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         kp_x_ff        <= 32'd16777;
         kp_y_ff        <= 32'd16777;
         kd_x_ff        <= 32'd117441;
         kd_y_ff        <= 32'd117441;
         ref_x_ff       <= '0;
         ref_y_ff       <= '0;
         inv_dt_ff      <= 32'd65536000;
         prev_full_x_ff <= '0;
         prev_full_y_ff <= '0;
         prev_inst_x_ff <= '0;
         prev_inst_y_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (reg_idx_type'(csr_index))
               REG_MODE:   mode_ff   <= csr_wdata[0];
               REG_KP_X:   kp_x_ff   <= csr_wdata;
               REG_KP_Y:   kp_y_ff   <= csr_wdata;
               REG_KD_X:   kd_x_ff   <= csr_wdata;
               REG_KD_Y:   kd_y_ff   <= csr_wdata;
               REG_REF_X:  ref_x_ff  <= csr_wdata;
               REG_REF_Y:  ref_y_ff  <= csr_wdata;
               REG_INV_DT: inv_dt_ff <= csr_wdata;
            endcase
         end
         if (cmd.out_load) begin
            if (mode_ff) begin
               prev_inst_x_ff <= cx_ff;
               prev_inst_y_ff <= cy_ff;
            end else begin
               prev_full_x_ff <= cx_ff;
               prev_full_y_ff <= cy_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_in) begin
         com_x_ff <= req_com_x;
         com_y_ff <= req_com_y;
         com_z_ff <= req_com_z;
         vel_x_ff <= req_vel_x;
         vel_y_ff <= req_vel_y;
      end
      if (cmd.mul_go) begin
         prod_ff <= {32'd0, mag} * {33'd0, g_sel};
         neg_ff  <= a_sel[OPA_W-1];
         sh_ff   <= sh_sel;
      end
      if (cmd.sqrt_step) begin
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_rad_ff  <= sq_rad_ff << 2;
      end
      if (cmd.wb_en) begin
         case (cmd.op)
            OP_Q: begin
               sq_rad_ff  <= shifted[SQ_W-1:0];
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
            end
            OP_VX:   cx_ff   <= sat32(res + com_add);
            OP_VY:   cy_ff   <= sat32(res + com_add);
            OP_DX:   cpdx_ff <= sat32(res);
            OP_DY:   cpdy_ff <= sat32(res);
            OP_PX:   acc_ff  <= res;
            OP_DKX:  tx_ff   <= sat32(acc_ff + res);
            OP_PY:   acc_ff  <= res;
            OP_DKY:  ty_ff   <= sat32(acc_ff + res);
            default: acc_ff  <= acc_ff;
         endcase
      end
      if (cmd.out_load) begin
         rsp_theta_x <= tx_ff;
         rsp_theta_y <= ty_ff;
         rsp_cp_x    <= cx_ff;
         rsp_cp_y    <= cy_ff;
      end
   end

endmodule

@@ rtl/capture_point_pd_stabilizer_unit.sv @@
// Top level of the capture point PD stabilizer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  com_x com_y com_z vel_x vel_y
//   rsp      out        rsp_valid/rsp_stall  theta_x theta_y cp_x cp_y
//   csr      in         csr_wr_en            csr_index csr_wdata
//
// An item runs through a transfer step, the height product, one step per root bit in the
// square root unit, an issue and a write-back step for each of eight products on the one
// shared multiplier, and a load of the result register.
// Reset restores register defaults and clears the stored capture points.
// The result register frees the input side: a new item is taken while the last result
// waits, and the block holds in its final step only if that result is still untaken.
module capture_point_pd_stabilizer_unit import cps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_com_x,
   input  logic signed [31:0] req_com_y,
   input  logic signed [31:0] req_com_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_theta_x,
   output logic signed [31:0] rsp_theta_y,
   output logic signed [31:0] rsp_cp_x,
   output logic signed [31:0] rsp_cp_y
);

   cmd_type cmd;

   cps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_com_x   (req_com_x),
      .req_com_y   (req_com_y),
      .req_com_z   (req_com_z),
      .req_vel_x   (req_vel_x),
      .req_vel_y   (req_vel_y),
      .rsp_theta_x (rsp_theta_x),
      .rsp_theta_y (rsp_theta_y),
      .rsp_cp_x    (rsp_cp_x),
      .rsp_cp_y    (rsp_cp_y)
   );

endmodule

@@ verif/capture_point_pd_stabilizer_unit_tb.sv @@
// Self-checking testbench for the capture point PD stabilizer, with its own result prediction.
module capture_point_pd_stabilizer_unit_tb import cps_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Q_FRAC = FRAC_BITS;
   localparam int G_FRAC = GAIN_FRAC;
   localparam longint unsigned INV_G = 64'd437815219;   // 2^32 / 9.81
   localparam int LATENCY = 48;
   localparam int N_PROBES = 14;
   localparam int N_PHASES = 10;
   localparam int PHASE_ITEMS = 50;

   typedef struct packed {
      logic signed [31:0] com_x;
      logic signed [31:0] com_y;
      logic signed [31:0] com_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } com_sample_type;

   typedef struct packed {
      logic signed [31:0] theta_x;
      logic signed [31:0] theta_y;
      logic signed [31:0] cp_x;
      logic signed [31:0] cp_y;
   } pd_result_type;

   typedef struct packed {
      logic               mode;
      logic [31:0]        kp_x;
      logic [31:0]        kp_y;
      logic [31:0]        kd_x;
      logic [31:0]        kd_y;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic [31:0]        inv_dt;
   } csr_image_type;

   typedef struct packed {
      logic           mode;
      logic           pinned;
      com_sample_type s;
      pd_result_type  r;
   } probe_row_type;

   localparam csr_image_type CSR_AT_RESET = '{1'b0, 32'd16777, 32'd16777, 32'd117441,
                                              32'd117441, 32'sd0, 32'sd0, 32'd65536000};

   localparam probe_row_type PROBE_ROWS [N_PROBES] = '{
      '{1'b0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0}},
      '{1'b0, 1'b1, '{32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
                    '{32'h0, 32'h0, 32'h0, 32'h0}},
      '{1'b0, 1'b0, '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0}, '0},
      '{1'b0, 1'b0, '{32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, '0},
      '{1'b0, 1'b0, '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000}, '0},
      '{1'b0, 1'b0, '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000}, '0},
      '{1'b0, 1'b0, '{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 32'h0001_0000,
                      32'hffff_0000}, '0},
      '{1'b1, 1'b0, '{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 32'h0001_0000,
                      32'hffff_0000}, '0},
      '{1'b1, 1'b0, '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                      32'h8000_0000}, '0},
      '{1'b1, 1'b0, '{32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, '0},
      '{1'b0, 1'b0, '{32'h0000_8000, 32'hffff_8000, 32'h0000_f000, 32'h0002_0000,
                      32'hfffe_0000}, '0},
      '{1'b0, 1'b0, '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                      32'h5555_5555}, '0},
      '{1'b0, 1'b0, '{32'haaaa_aaaa, 32'h5555_5555, 32'h2aaa_aaaa, 32'h5555_5555,
                      32'haaaa_aaaa}, '0},
      '{1'b1, 1'b0, '{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                      32'h0000_0001}, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_com_x = '0;
   logic signed [31:0] req_com_y = '0;
   logic signed [31:0] req_com_z = '0;
   logic signed [31:0] req_vel_x = '0;
   logic signed [31:0] req_vel_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_theta_x;
   logic signed [31:0] rsp_theta_y;
   logic signed [31:0] rsp_cp_x;
   logic signed [31:0] rsp_cp_y;

   csr_image_type      live_csr = CSR_AT_RESET;
   logic signed [31:0] last_cp_full_x = '0;
   logic signed [31:0] last_cp_full_y = '0;
   logic signed [31:0] last_cp_inst_x = '0;
   logic signed [31:0] last_cp_inst_y = '0;
   pd_result_type      expected_corrections [$];
   bit                 mismatch_seen = 1'b0;
   bit                 steady_flow = 1'b0;

   capture_point_pd_stabilizer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_com_x   (req_com_x),
      .req_com_y   (req_com_y),
      .req_com_z   (req_com_z),
      .req_vel_x   (req_vel_x),
      .req_vel_y   (req_vel_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_theta_x (rsp_theta_x),
      .rsp_theta_y (rsp_theta_y),
      .rsp_cp_x    (rsp_cp_x),
      .rsp_cp_y    (rsp_cp_y)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // (a * g) >> sh, rounded toward zero
   function automatic longint trunc_scale(longint a, longint unsigned g, int sh);
      longint unsigned mag;
      longint unsigned p;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      p = (mag * g) >> sh;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] pd_axis(longint cp, longint last, longint target,
                                                  logic [31:0] kp, logic [31:0] kd);
      longint rate_term;
      longint sum;
      rate_term = clamp32(trunc_scale(cp - last, live_csr.inv_dt, Q_FRAC));
      sum = trunc_scale(cp - target, kp, G_FRAC) + trunc_scale(rate_term, kd, G_FRAC);
      return clamp32(sum);
   endfunction

   function automatic pd_result_type predict_correction(com_sample_type s);
      longint unsigned h;
      longint unsigned root;
      longint          cx;
      longint          cy;
      pd_result_type   r;
      h = (s.com_z < 0) ? 64'd0 : 64'(s.com_z);
      root = root_floor((h * INV_G) >> (32 - Q_FRAC));
      cx = trunc_scale(s.vel_x, root, Q_FRAC);
      cy = trunc_scale(s.vel_y, root, Q_FRAC);
      if (live_csr.mode == 1'b0) begin
         r.cp_x = clamp32(cx + s.com_x);
         r.cp_y = clamp32(cy + s.com_y);
         r.theta_x = pd_axis(r.cp_x, last_cp_full_x, live_csr.target_x,
                             live_csr.kp_x, live_csr.kd_x);
         r.theta_y = pd_axis(r.cp_y, last_cp_full_y, live_csr.target_y,
                             live_csr.kp_y, live_csr.kd_y);
         last_cp_full_x = r.cp_x;
         last_cp_full_y = r.cp_y;
      end else begin
         r.cp_x = clamp32(cx);
         r.cp_y = clamp32(cy);
         r.theta_x = pd_axis(r.cp_x, last_cp_inst_x, live_csr.target_x,
                             live_csr.kp_x, live_csr.kd_x);
         r.theta_y = pd_axis(r.cp_y, last_cp_inst_y, live_csr.target_y,
                             live_csr.kp_y, live_csr.kd_y);
         last_cp_inst_x = r.cp_x;
         last_cp_inst_y = r.cp_y;
      end
      return r;
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] near_zero(int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic [31:0] pick_gain();
      return ($urandom_range(1) != 0) ? 32'($urandom_range(0, 32'h0400_0000)) : any_word();
   endfunction

   // mostly plausible posture data, the rest raw words
   function automatic com_sample_type pick_sample();
      com_sample_type s;
      if ($urandom_range(99) < 75) begin
         s.com_x = near_zero(32'h2_0000);
         s.com_y = near_zero(32'h2_0000);
         s.com_z = ($urandom_range(99) < 5) ? near_zero(32'h1_0000)
                                            : 32'($urandom_range(0, 32'h2_0000));
         s.vel_x = near_zero(32'h4_0000);
         s.vel_y = near_zero(32'h4_0000);
      end else begin
         s.com_x = any_word();
         s.com_y = any_word();
         s.com_z = any_word();
         s.vel_x = any_word();
         s.vel_y = any_word();
      end
      return s;
   endfunction

   function automatic csr_image_type pick_settings(int phase);
      csr_image_type c;
      case (phase)
         0: c = '{1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
         1: c = '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h8000_0000, 32'h8000_0000, 32'h0};
         2: c = '{1'b0, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h1};
         3: begin
            c = CSR_AT_RESET;
            c.mode = 1'b1;
         end
         default: begin
            c.mode = 1'($urandom_range(1));
            c.kp_x = pick_gain();
            c.kp_y = pick_gain();
            c.kd_x = pick_gain();
            c.kd_y = pick_gain();
            c.target_x = ($urandom_range(1) != 0) ? near_zero(32'h1_0000) : any_word();
            c.target_y = ($urandom_range(1) != 0) ? near_zero(32'h1_0000) : any_word();
            c.inv_dt = ($urandom_range(3) != 0) ? 32'($urandom_range(32'h1_0000, 32'h400_0000))
                                                : any_word();
         end
      endcase
      return c;
   endfunction

   task automatic load_csr(csr_image_type img);
      reg_idx_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = reg_idx_type'(i);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         case (idx)
            REG_MODE:   csr_wdata <= {31'($urandom), img.mode};
            REG_KP_X:   csr_wdata <= img.kp_x;
            REG_KP_Y:   csr_wdata <= img.kp_y;
            REG_KD_X:   csr_wdata <= img.kd_x;
            REG_KD_Y:   csr_wdata <= img.kd_y;
            REG_REF_X:  csr_wdata <= img.target_x;
            REG_REF_Y:  csr_wdata <= img.target_y;
            REG_INV_DT: csr_wdata <= img.inv_dt;
            default:    csr_wdata <= '0;
         endcase
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      live_csr = img;
   endtask

   task automatic offer_sample(com_sample_type s, bit pinned, pd_result_type pinned_out);
      pd_result_type want;
      req_valid <= 1'b1;
      req_com_x <= s.com_x;
      req_com_y <= s.com_y;
      req_com_z <= s.com_z;
      req_vel_x <= s.vel_x;
      req_vel_y <= s.vel_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_correction(s);
      if (pinned) want = pinned_out;
      expected_corrections.push_back(want);
   endtask

   task automatic maybe_idle();
      if (!steady_flow && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_corrections.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      pd_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_corrections.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatch_seen = 1'b1;
            end else begin
               want = expected_corrections.pop_front();
               compare_field("theta_x", want.theta_x, rsp_theta_x);
               compare_field("theta_y", want.theta_y, rsp_theta_y);
               compare_field("cp_x", want.cp_x, rsp_cp_x);
               compare_field("cp_y", want.cp_y, rsp_cp_y);
            end
         end
         rsp_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 24);
      end
   end

   initial begin
      csr_image_type img;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_PROBES; i++) begin
         if (PROBE_ROWS[i].mode != live_csr.mode) begin
            settle();
            img = live_csr;
            img.mode = PROBE_ROWS[i].mode;
            load_csr(img);
         end
         offer_sample(PROBE_ROWS[i].s, PROBE_ROWS[i].pinned, PROBE_ROWS[i].r);
         if (i + 1 < N_PROBES && PROBE_ROWS[i + 1].mode == PROBE_ROWS[i].mode) maybe_idle();
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         load_csr(pick_settings(p));
         steady_flow = (p == 5 || p == 6);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            offer_sample(pick_sample(), 1'b0, '0);
            if (k + 1 < PHASE_ITEMS) maybe_idle();
         end
         steady_flow = 1'b0;
      end

      settle();
      if (!mismatch_seen) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
